// ===== rtl/spk_pkg.sv =====
package spk_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned Rounds  = 22;
  localparam int unsigned RoundW  = 5;
  localparam int unsigned RotA    = 7;
  localparam int unsigned RotB    = 2;
  localparam int unsigned KeyW    = 64;

  typedef logic [WordW-1:0] word_t;

  // One byte job: payload plus everything the round pipeline needs
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] pos;
    logic       newblk;
    word_t      x;
    word_t      y;
    word_t      k;
    word_t      l0;
    word_t      l1;
    word_t      l2;
  } job_t;

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = (v >> s) | (v << (WordW - s));
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (WordW - s));
  endfunction

endpackage

// ===== rtl/spk_front.sv =====
module spk_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_data_byte,
  input  logic [15:0]               in_nonce,
  input  logic                      in_last,
  input  logic [spk_pkg::KeyW-1:0]  key,
  input  logic                      pop,
  output logic                      job_valid,
  output spk_pkg::job_t             job
);

  logic [15:0]   ctr_r, ctr_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          wptr_r, wptr_nxt;
  logic          rptr_r, rptr_nxt;
  spk_pkg::job_t q_r [0:1];
  spk_pkg::job_t push_job;
  logic          push;
  logic          do_pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign do_pop    = pop && job_valid;
  assign job       = q_r[rptr_r];

  // classify the beat: block start takes nonce and counter as plaintext
  always_comb begin
    push_job.data   = in_data_byte;
    push_job.last   = in_last;
    push_job.pos    = pos_r;
    push_job.newblk = (pos_r == 2'd0);
    push_job.x      = in_nonce;
    push_job.y      = ctr_r;
    push_job.k      = key[15:0];
    push_job.l0     = key[31:16];
    push_job.l1     = key[47:32];
    push_job.l2     = key[63:48];
  end

  // block counter and byte position
  always_comb begin
    ctr_nxt = ctr_r;
    pos_nxt = pos_r;
    if (push) begin
      if (in_last) begin
        ctr_nxt = '0;
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 2'd1;
        if (pos_r == 2'd0) begin
          ctr_nxt = ctr_r + 16'd1;
        end
      end
    end
  end

  // two-entry queue pointers
  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r  <= '0;
      pos_r  <= '0;
      cnt_r  <= '0;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
    end else begin
      ctr_r  <= ctr_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/spk_round.sv =====
module spk_round (
  input  logic [spk_pkg::RoundW-1:0] rnd,
  input  spk_pkg::job_t              din,
  output spk_pkg::job_t              dout
);

  spk_pkg::word_t xs, xn, yn, nl, kn;

  // data round, then key schedule step on the rotating l queue
  always_comb begin
    xs = spk_pkg::rotr(din.x, spk_pkg::RotA) + din.y;
    xn = xs ^ din.k;
    yn = spk_pkg::rotl(din.y, spk_pkg::RotB) ^ xn;
    nl = (din.k + spk_pkg::rotr(din.l0, spk_pkg::RotA))
         ^ spk_pkg::word_t'(rnd);
    kn = spk_pkg::rotl(din.k, spk_pkg::RotB) ^ nl;

    dout    = din;
    dout.x  = xn;
    dout.y  = yn;
    dout.k  = kn;
    dout.l0 = din.l1;
    dout.l1 = din.l2;
    dout.l2 = nl;
  end

endmodule

// ===== rtl/spk_back.sv =====
module spk_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  spk_pkg::job_t job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  localparam int unsigned N = spk_pkg::Rounds;

  spk_pkg::job_t st_r   [0:N];
  spk_pkg::job_t st_nxt [1:N];
  logic [N:0]    v_r;
  logic          adv;
  logic [31:0]   kw_r, kw_sel;
  logic [7:0]    ks;
  logic          ov_r;
  logic [7:0]    ob_r;
  logic          ol_r;

  // whole pipeline moves when the output register is free
  assign adv       = !ov_r || out_ready;
  assign pop       = adv;
  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

  // one round per stage
  for (genvar g = 0; g < N; g++) begin : g_rnd
    spk_round u_round (
      .rnd  (spk_pkg::RoundW'(g)),
      .din  (st_r[g]),
      .dout (st_nxt[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[N-1:0], job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= job;
      for (int i = 1; i <= N; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // pick the keystream byte: fresh block or the held word
  always_comb begin
    kw_sel = st_r[N].newblk ? {st_r[N].x, st_r[N].y} : kw_r;
    case (st_r[N].pos)
      2'd0:    ks = kw_sel[31:24];
      2'd1:    ks = kw_sel[23:16];
      2'd2:    ks = kw_sel[15:8];
      default: ks = kw_sel[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      kw_r <= '0;
    end else if (adv) begin
      ov_r <= v_r[N];
      if (v_r[N] && st_r[N].newblk) begin
        kw_r <= kw_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[N]) begin
      ob_r <= st_r[N].data ^ ks;
      ol_r <= st_r[N].last;
    end
  end

endmodule

// ===== rtl/speck32_ctr_byte_cipher_top.sv =====
// Speck 32/64 CTR byte cipher.
// Input beat to output beat: queue, input stage, 22 round stages, output register.
// Throughput: one beat per cycle unless out_ready stalls the fully pipelined rounds.
// Reset (rst_n low, synchronous): clears key, counter, byte position, queue and valids.
// Key writes are taken on any cycle; the key is sampled per beat on entry.
module speck32_ctr_byte_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_speck_key,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_nonce,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  logic [spk_pkg::KeyW-1:0] key_r;
  logic                     job_valid;
  logic                     pop;
  spk_pkg::job_t            job;

  assign cfg_ready = 1'b1;

  // key register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      key_r <= cfg_speck_key;
    end
  end

  spk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_nonce     (in_nonce),
    .in_last      (in_last),
    .key          (key_r),
    .pop          (pop),
    .job_valid    (job_valid),
    .job          (job)
  );

  spk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== bench/speck32_ctr_byte_cipher_top_tb.sv =====
module speck32_ctr_byte_cipher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef spk_pkg::word_t word_t;

  localparam int unsigned CycleLimit = 100_000;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned PrintCap   = 40;

  typedef struct {
    logic [7:0] text;
    logic       flag_last;
  } cipher_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_speck_key = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic [15:0] in_nonce = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last;

  // keystream state kept alongside the block
  logic [63:0] key_shadow;
  word_t       block_ctr;
  logic [1:0]  byte_pos;
  logic [31:0] ks_word;

  cipher_beat_t pending_text[$];
  cipher_beat_t want_beat;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned key_writes;
  int unsigned gap_pct;
  int unsigned stall_pct;

  speck32_ctr_byte_cipher_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_speck_key (cfg_speck_key),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_nonce      (in_nonce),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Speck 32/64 block encryption, 22 rounds
  function automatic logic [31:0] speck_block(input word_t x, input word_t y,
                                              input logic [63:0] key);
    word_t a;
    word_t b;
    word_t rk;
    word_t nl;
    word_t lw[3];
    int    r;
    a     = x;
    b     = y;
    rk    = key[15:0];
    lw[0] = key[31:16];
    lw[1] = key[47:32];
    lw[2] = key[63:48];
    for (r = 0; r < 22; r++) begin
      a = {a[6:0], a[15:7]} + b;
      a = a ^ rk;
      b = {b[13:0], b[15:14]} ^ a;
      if (r < 21) begin
        nl = rk + {lw[r % 3][6:0], lw[r % 3][15:7]};
        nl = nl ^ word_t'(r);
        rk = {rk[13:0], rk[15:14]} ^ nl;
        lw[r % 3] = nl;
      end
    end
    return {a, b};
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    // keep the log short if the block is badly broken
    if (mismatch_count <= PrintCap)
      $display("t=%0t %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // one accepted beat: work out the byte the block must return
  task automatic apply_keystream(input logic [7:0] data, input word_t nonce, input logic last);
    cipher_beat_t nb;
    logic [7:0]   ks_byte;
    if (byte_pos == 2'd0) begin
      ks_word   = speck_block(nonce, block_ctr, key_shadow);
      block_ctr = block_ctr + 16'd1;
    end
    ks_byte      = 8'(ks_word >> (24 - 8 * int'(byte_pos)));
    nb.text      = data ^ ks_byte;
    nb.flag_last = last;
    pending_text.push_back(nb);
    if (last) begin
      block_ctr = '0;
      byte_pos  = '0;
    end else begin
      byte_pos = byte_pos + 2'd1;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_out <= beats_out + 1;
      if (pending_text.size() == 0) begin
        report_mismatch("beat with nothing expected", out_byte, 0);
      end else begin
        want_beat = pending_text.pop_front();
        if (out_byte !== want_beat.text)
          report_mismatch("out_byte", out_byte, want_beat.text);
        if (out_last !== want_beat.flag_last)
          report_mismatch("out_last", out_last, want_beat.flag_last);
      end
    end
  end

  // send one input beat, idling at random beforehand; returns at the accepting edge
  task automatic send_byte(input logic [7:0] data, input word_t nonce, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_nonce     <= nonce;
    in_last      <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_in++;
    apply_keystream(data, nonce, last);
  endtask

  // wait for the block to go quiet
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] key);
    cfg_valid     <= 1'b1;
    cfg_speck_key <= key;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    key_shadow = key;
    key_writes++;
  endtask

  // field extremes, last on every position, nonce changes, key swap mid-message
  task automatic test_directed;
    gap_pct   = 0;
    stall_pct = 0;
    if (speck_block(16'h6574, 16'h694c, 64'h1918_1110_0908_0100) !== 32'ha868_42f2)
      report_mismatch("cipher vector",
                      speck_block(16'h6574, 16'h694c, 64'h1918_1110_0908_0100),
                      32'ha868_42f2);
    // reset key, last on position 2
    send_byte(8'h00, 16'h0000, 1'b0);
    send_byte(8'hFF, 16'h0000, 1'b0);
    send_byte(8'h5A, 16'h0000, 1'b1);
    drain();
    write_key(64'h1918_1110_0908_0100);
    // single-byte message, last on position 0
    send_byte(8'hFF, 16'hFFFF, 1'b1);
    // full block, last on position 3
    send_byte(8'h00, 16'h6574, 1'b0);
    send_byte(8'h01, 16'h6574, 1'b0);
    send_byte(8'h80, 16'h6574, 1'b0);
    send_byte(8'hFF, 16'h6574, 1'b1);
    // nonce moving inside blocks; last on position 1
    send_byte(8'hA5, 16'h1234, 1'b0);
    send_byte(8'h5A, 16'hFFFF, 1'b0);
    send_byte(8'h3C, 16'h0000, 1'b0);
    send_byte(8'hC3, 16'h8001, 1'b0);
    send_byte(8'h7E, 16'hAAAA, 1'b0);
    send_byte(8'h81, 16'h5555, 1'b1);
    // key changed part way through a block
    send_byte(8'h11, 16'h0F0F, 1'b0);
    send_byte(8'h22, 16'h0F0F, 1'b0);
    send_byte(8'h33, 16'h0F0F, 1'b0);
    drain();
    write_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'h44, 16'h0F0F, 1'b0);
    send_byte(8'h55, 16'h0F0F, 1'b0);
    send_byte(8'h66, 16'h0F0F, 1'b1);
  endtask

  // random messages under one key and one idling pattern
  task automatic test_random_traffic(input int unsigned n_beats, input int unsigned gap,
                                     input int unsigned stall, input logic [63:0] key);
    int unsigned left;
    word_t       nonce;
    logic        last;
    drain();
    write_key(key);
    gap_pct   = gap;
    stall_pct = stall;
    left      = 0;
    nonce     = '0;
    for (int unsigned n = 0; n < n_beats; n++) begin
      if (left == 0) begin
        left = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        case ($urandom_range(7))
          0:       nonce = 16'h0000;
          1:       nonce = 16'hFFFF;
          default: nonce = word_t'($urandom);
        endcase
      end else if ($urandom_range(15) == 0) begin
        // stray nonce inside a message
        nonce = word_t'($urandom);
      end
      last = (left == 1);
      send_byte(8'($urandom), nonce, last);
      left--;
    end
  endtask

  initial begin
    key_shadow     = '0;
    block_ctr      = '0;
    byte_pos       = '0;
    ks_word        = '0;
    cycle_count    = 0;
    mismatch_count = 0;
    beats_in       = 0;
    beats_out      = 0;
    key_writes     = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(210, 0, 0, 64'h0);
    test_random_traffic(210, 64, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    test_random_traffic(210, 0, 64, {$urandom, $urandom});
    test_random_traffic(210, 33, 33, {$urandom, $urandom});
    drain();

    $display("Covered %0d beats in and %0d out under %0d keys, idle and stall mixes,",
             beats_in, beats_out, key_writes);
    $display("last on every byte position, and mid-block nonce and key changes.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spk_pkg.sv
rtl/spk_front.sv
rtl/spk_round.sv
rtl/spk_back.sv
rtl/speck32_ctr_byte_cipher_top.sv
bench/speck32_ctr_byte_cipher_top_tb.sv
